@@ src/cww_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cww_pkg
// Shared widths, register indexes, pipeline word type and pixel helper of
// the clockwise wipe mixer.
// ----------------------------------------------------------------------------
package cww_pkg;

  localparam int VAL_W     = 16;  // angle, progress, speed, max_dim, offset
  localparam int PIX_W     = 8;
  localparam int GW_W      = 14;
  localparam int GS_W      = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Glow division: numerator < 2^22, quotient in 0..256
  localparam int DIV_W      = 22;
  localparam int DIV_STAGES = 9;

  localparam logic [VAL_W-1:0] PROG_MAX   = 16'hFFFF;
  localparam logic [GW_W-1:0]  GW_LIMIT   = 14'd8192;
  localparam logic [GS_W-1:0]  GS_LIMIT   = 8'd180;
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPAND_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALO_SPAN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALO_GAIN     = 3'd5;

  localparam logic [VAL_W-1:0] SPEED_RST   = 16'd1;
  localparam logic [VAL_W-1:0] MAX_DIM_RST = 16'd1920;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Pixel word carried down the pipeline: chosen pixel plus incoming chroma
  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] un;
    logic [PIX_W-1:0] vn;
  } pix_t;

  // (a*(256-m) + b*m + 128) >> 8, m in 0..64
  function automatic logic [PIX_W-1:0] mix_u8(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [6:0] m);
    logic [8:0]  wa;
    logic [17:0] t;
    wa = 9'd256 - {2'b00, m};
    t  = 18'(a) * 18'(wa) + 18'(b) * 18'(m) + 18'd128;
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

@@ src/cww_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cww_req_if
// Request channel: frame ticks and pixel pairs with their angle.
// ----------------------------------------------------------------------------
interface cww_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] angle;
  logic [7:0]  y_cur;
  logic [7:0]  u_cur;
  logic [7:0]  v_cur;
  logic [7:0]  y_next;
  logic [7:0]  u_next;
  logic [7:0]  v_next;

  modport source (output valid, req_type, angle, y_cur, u_cur, v_cur,
                  y_next, u_next, v_next, input ready);
  modport sink   (input valid, req_type, angle, y_cur, u_cur, v_cur,
                  y_next, u_next, v_next, output ready);
endinterface
`default_nettype wire

@@ src/cww_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cww_rsp_if
// Result channel: one mixed YUV pixel per pixel request.
// ----------------------------------------------------------------------------
interface cww_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] y_out;
  logic [7:0] u_out;
  logic [7:0] v_out;

  modport source (output valid, y_out, u_out, v_out, input ready);
  modport sink   (input valid, y_out, u_out, v_out, output ready);
endinterface
`default_nettype wire

@@ src/cww_step_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cww_step_div
// Serial restoring divider: step = min(speed,max_dim)*65535 / max_dim,
// one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module cww_step_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cww_pkg::VAL_W-1:0] speed,
  input  wire logic [cww_pkg::VAL_W-1:0] max_dim,
  output logic                           busy,
  output logic [cww_pkg::VAL_W-1:0]      step
);
  import cww_pkg::*;

  logic [VAL_W-1:0]   md;
  logic [VAL_W-1:0]   sc;
  logic [2*VAL_W-1:0] dvd;
  logic [VAL_W:0]     trial;
  logic               ge;

  logic [VAL_W-1:0]   rem;
  logic [VAL_W-1:0]   shf;   // dividend bits out, quotient bits in
  logic [VAL_W-1:0]   dsr;
  logic               s_nz;
  logic [3:0]         cnt;

  // Clamp operands; s*65535 as s*65536 - s
  always_comb begin
    md  = (max_dim == '0) ? VAL_W'(1) : max_dim;
    sc  = (speed > md) ? md : speed;
    dvd = {sc, {VAL_W{1'b0}}} - {{VAL_W{1'b0}}, sc};
    trial = {rem, shf[VAL_W-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dvd[2*VAL_W-1:VAL_W];
      shf  <= dvd[VAL_W-1:0];
      dsr  <= md;
      s_nz <= (sc != '0);
    end else if (busy) begin
      rem <= ge ? VAL_W'(trial - {1'b0, dsr}) : trial[VAL_W-1:0];
      shf <= {shf[VAL_W-2:0], ge};
    end
  end

  assign step = (s_nz && shf == '0) ? VAL_W'(1) : shf;

endmodule
`default_nettype wire

@@ src/clockwise_wipe_transition_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clockwise_wipe_transition_mixer
// Clockwise wipe between two YUV streams with a glow band at the wipe edge.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  req      in   valid/ready    req_type, angle, cur pixel, next pixel
//  rsp      out  valid/ready    y_out, u_out, v_out (pixel requests only)
//  cfg      in   cfg_we         cfg_index, cfg_data (write only)
//
//  One request word per cycle while req.ready is high; a pixel result passes
//  through the 9-stage glow divider plus five mixing stages.
//  Frame ticks update progress on acceptance and leave no result.
//  After reset and after each write to speed or max_dim, req.ready stays low
//  while the serial step divider runs.
//  A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module clockwise_wipe_transition_mixer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cww_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cww_pkg::CFG_DAT_W-1:0] cfg_data,
  cww_req_if.sink                            req,
  cww_rsp_if.source                          rsp
);
  import cww_pkg::*;

  // Configuration registers
  logic [VAL_W-1:0] speed;
  logic             bounce_mode;
  logic [VAL_W-1:0] max_dim;
  logic [VAL_W-1:0] expand_offset;
  logic [GW_W-1:0]  halo_span;
  logic [GS_W-1:0]  halo_gain;

  // Wipe state
  logic [VAL_W-1:0] progress;
  logic             direction_down;
  logic [VAL_W-1:0] progress_next;
  logic             direction_down_next;

  // Step divider control
  logic             step_pending;
  logic             div_start;
  logic             div_busy;
  logic [VAL_W-1:0] step;

  // Handshake
  logic adv;   // whole pipeline moves
  logic acc;   // request word taken

  // Clamped glow settings
  logic [GW_W-1:0]  gw;
  logic [GS_W-1:0]  gs;
  logic             glow_en;

  // Stage 1: captured request and threshold
  logic             s1_vld;
  logic [VAL_W-1:0] s1_angle;
  logic [VAL_W-1:0] s1_p;
  pix_t             s1_cur;   // y/u/v current, un/vn incoming
  logic [PIX_W-1:0] s1_yn;
  logic [VAL_W:0]   p_sum;

  // Stage 2: chosen pixel and angular distance
  logic             s2_vld;
  pix_t             s2_pix;
  logic [VAL_W-1:0] s2_d;

  // Glow divider pipeline, index 0 is stage 3
  logic             dv_vld [0:DIV_STAGES];
  logic             dv_hit [0:DIV_STAGES];
  pix_t             dv_pix [0:DIV_STAGES];
  logic [DIV_W-1:0] dv_rem [0:DIV_STAGES];
  logic [8:0]       dv_q   [0:DIV_STAGES];

  // Scale stage
  logic             sd_vld;
  logic             sd_hit;
  pix_t             sd_pix;
  logic [PIX_W-1:0] sd_add;
  logic [6:0]       sd_m;
  logic [16:0]      sd_prod;

  // Output register
  logic             out_vld;
  logic [PIX_W-1:0] y_o;
  logic [PIX_W-1:0] u_o;
  logic [PIX_W-1:0] v_o;
  logic [PIX_W:0]   y_sum;

  // --------------------------------------------------------------------------
  // Configuration writes; a write to speed or max_dim reruns the step divide
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      speed         <= SPEED_RST;
      bounce_mode   <= 1'b1;
      max_dim       <= MAX_DIM_RST;
      expand_offset <= '0;
      halo_span     <= '0;
      halo_gain     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED:         speed         <= cfg_data[VAL_W-1:0];
        REG_BOUNCE_MODE:   bounce_mode   <= cfg_data[0];
        REG_MAX_DIM:       max_dim       <= cfg_data[VAL_W-1:0];
        REG_EXPAND_OFFSET: expand_offset <= cfg_data[VAL_W-1:0];
        REG_HALO_SPAN:     halo_span     <= cfg_data[GW_W-1:0];
        REG_HALO_GAIN:     halo_gain     <= cfg_data[GS_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_start = step_pending && !div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_pending <= 1'b1;
    end else begin
      step_pending <= (step_pending && !div_start) ||
                      (cfg_we && (cfg_index == REG_SPEED || cfg_index == REG_MAX_DIM));
    end
  end

  cww_step_div u_step_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .speed   (speed),
    .max_dim (max_dim),
    .busy    (div_busy),
    .step    (step)
  );

  always_comb begin
    gw      = (halo_span > GW_LIMIT) ? GW_LIMIT : halo_span;
    gs      = (halo_gain > GS_LIMIT) ? GS_LIMIT : halo_gain;
    glow_en = (gw != '0) && (gs != '0);
  end

  // --------------------------------------------------------------------------
  // Handshake: hold everything while the output word waits
  // --------------------------------------------------------------------------
  assign adv       = !out_vld || rsp.ready;
  assign req.ready = adv && !step_pending && !div_busy;
  assign acc       = req.valid && req.ready;

  // --------------------------------------------------------------------------
  // Progress: advance on every accepted frame tick
  // --------------------------------------------------------------------------
  always_comb begin
    logic [VAL_W:0] up_sum;
    up_sum              = {1'b0, progress} + {1'b0, step};
    progress_next       = progress;
    direction_down_next = direction_down;
    if (!bounce_mode) begin
      progress_next       = up_sum[VAL_W-1:0];
      direction_down_next = 1'b0;
    end else if (direction_down) begin
      if (step >= progress) begin
        progress_next       = '0;
        direction_down_next = 1'b0;
      end else begin
        progress_next = progress - step;
      end
    end else begin
      if (up_sum >= {1'b0, PROG_MAX}) begin
        progress_next       = PROG_MAX;
        direction_down_next = 1'b1;
      end else begin
        progress_next = up_sum[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress       <= '0;
      direction_down <= 1'b0;
    end else if (acc && req.req_type == REQ_TICK) begin
      progress       <= progress_next;
      direction_down <= direction_down_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture pixel word with saturated threshold progress+offset
  // --------------------------------------------------------------------------
  assign p_sum = {1'b0, progress} + {1'b0, expand_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= acc && req.req_type == REQ_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_angle  <= req.angle;
      s1_p      <= p_sum[VAL_W] ? PROG_MAX : p_sum[VAL_W-1:0];
      s1_cur.y  <= req.y_cur;
      s1_cur.u  <= req.u_cur;
      s1_cur.v  <= req.v_cur;
      s1_cur.un <= req.u_next;
      s1_cur.vn <= req.v_next;
      s1_yn     <= req.y_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the side of the wipe, measure distance to the edge
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_angle <= s1_p) begin
        s2_pix.y <= s1_yn;
        s2_pix.u <= s1_cur.un;
        s2_pix.v <= s1_cur.vn;
      end else begin
        s2_pix.y <= s1_cur.y;
        s2_pix.u <= s1_cur.u;
        s2_pix.v <= s1_cur.v;
      end
      s2_pix.un <= s1_cur.un;
      s2_pix.vn <= s1_cur.vn;
      s2_d      <= (s1_angle >= s1_p) ? s1_angle - s1_p : s1_p - s1_angle;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: glow hit test and divider numerator (gw-d)*256 + gw/2
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_hit[0] <= glow_en && (s2_d < {{(VAL_W-GW_W){1'b0}}, gw});
      dv_pix[0] <= s2_pix;
      dv_rem[0] <= {gw - s2_d[GW_W-1:0], 8'h00} + DIV_W'(gw[GW_W-1:1]);
      dv_q[0]   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Glow divider: one quotient bit per stage, MSB first
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int SH = DIV_STAGES - 1 - k;
    logic [DIV_W-1:0] dsr;
    logic             ge;

    assign dsr = DIV_W'(gw) << SH;
    assign ge  = dv_rem[k] >= dsr;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_hit[k+1] <= dv_hit[k];
        dv_pix[k+1] <= dv_pix[k];
        dv_rem[k+1] <= ge ? dv_rem[k] - dsr : dv_rem[k];
        dv_q[k+1]   <= {dv_q[k][7:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale stage: luma boost (gs*q+128)>>8 and chroma weight q>>2
  // --------------------------------------------------------------------------
  assign sd_prod = 17'(gs) * 17'(dv_q[DIV_STAGES]) + 17'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_vld <= 1'b0;
    end else if (adv) begin
      sd_vld <= dv_vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_hit <= dv_hit[DIV_STAGES];
      sd_pix <= dv_pix[DIV_STAGES];
      sd_add <= sd_prod[15:8];
      sd_m   <= dv_q[DIV_STAGES][8:2];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: on a glow hit, saturating luma boost, chroma blend toward incoming
  // --------------------------------------------------------------------------
  assign y_sum = {1'b0, sd_pix.y} + {1'b0, sd_add};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= sd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd_hit) begin
        y_o <= y_sum[PIX_W] ? PIX_MAX : y_sum[PIX_W-1:0];
        u_o <= mix_u8(sd_pix.u, sd_pix.un, sd_m);
        v_o <= mix_u8(sd_pix.v, sd_pix.vn, sd_m);
      end else begin
        y_o <= sd_pix.y;
        u_o <= sd_pix.u;
        v_o <= sd_pix.v;
      end
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.y_out = y_o;
  assign rsp.u_out = u_o;
  assign rsp.v_out = v_o;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_during_divide: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!div_busy && !step_pending))
    else $error("request taken while step divide runs");

  a_tick_no_word: assert property (@(posedge clk) disable iff (rst)
    (acc && req.req_type == REQ_TICK) |=> !s1_vld)
    else $error("frame tick entered the pixel pipeline");

  a_loop_forward: assert property (@(posedge clk) disable iff (rst)
    (acc && req.req_type == REQ_TICK && !bounce_mode) |=> !direction_down)
    else $error("loop mode left direction down");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !rsp.ready) |=> ($stable(sd_vld) && $stable(s1_vld)))
    else $error("pipeline moved during output stall");

endmodule
`default_nettype wire
